[rtl/base64url_stream_codec_macros.svh]
`ifndef BASE64URL_STREAM_CODEC_MACROS_SVH
`define BASE64URL_STREAM_CODEC_MACROS_SVH

// same-cycle implication, checked while out of reset
`define B64U_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64u assertion failed");

// next-cycle implication, checked while out of reset
`define B64U_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64u assertion failed");

`endif

[rtl/b64u_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package b64u_pkg;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam int QUEUE_DEPTH = 2;

	// one finished group: up to four result bytes
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nres;
		logic            last;
		logic            bad;
	} cmd_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			r = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			r = 8'h2D;
		end else begin
			r = 8'h5F;
		end
		return r;
	endfunction

	function automatic logic [5:0] dec_value(input logic [7:0] c);
		logic [5:0] r;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2D) begin
			r = 6'd62;
		end else if (c == 8'h5F) begin
			r = 6'd63;
		end else begin
			r = 6'd0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/b64u_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module b64u_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic            cfg_mode,
	input  wire logic            in_fire,
	input  wire logic [7:0]      in_byte,
	input  wire logic            in_last,
	output logic                 push,
	output b64u_pkg::cmd_t       cmd
);
	import b64u_pkg::*;

	mode_t       mode_q;
	logic [23:0] gb_q;
	logic [1:0]  cnt_q;
	logic [2:0]  pad_q;

	logic [23:0] gb_n;
	logic [1:0]  cnt_n;
	logic [2:0]  pad_n;
	logic        push_c;
	cmd_t        cmd_c;

	logic [1:0]  cnt_e;
	logic [23:0] gb_e;
	logic [23:0] ins;
	logic [2:0]  n;
	logic [2:0]  nchars;
	logic [5:0]  v;
	logic [2:0]  pad_i;

	always_comb begin
		gb_n   = gb_q;
		cnt_n  = cnt_q;
		pad_n  = pad_q;
		push_c = 1'b0;
		cmd_c  = '0;
		cnt_e  = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
		gb_e   = (cnt_q == 2'd3) ? 24'd0 : gb_q;
		ins    = '0;
		n      = 3'd0;
		nchars = 3'd0;
		v      = dec_value(in_byte);
		pad_i  = (in_byte == PAD_CHAR && pad_q < 3'd4) ? pad_q + 3'd1 : pad_q;
		if (mode_q == MODE_ENC) begin
			unique case (cnt_e)
				2'd0:    ins = {in_byte, 16'h0000};
				2'd1:    ins = {8'h00, in_byte, 8'h00};
				2'd2:    ins = {16'h0000, in_byte};
				default: ins = '0;
			endcase
			gb_n = gb_e | ins;
			n    = {1'b0, cnt_e} + 3'd1;
			if (n < 3'd3 && !in_last) begin
				cnt_n = n[1:0];
				if (cnt_q == 2'd3) begin
					pad_n = 3'd0;
				end
			end else begin
				nchars = (n >= 3'd3) ? 3'd4 : n + 3'd1;
				for (int j = 0; j < 4; j++) begin
					cmd_c.bytes[j] = (3'(j) < nchars) ?
						enc_char(gb_n[23 - 6 * j -: 6]) : PAD_CHAR;
				end
				cmd_c.nres = 3'd4;
				cmd_c.last = in_last;
				push_c     = 1'b1;
				gb_n       = '0;
				cnt_n      = '0;
				pad_n      = '0;
			end
		end else begin
			unique case (cnt_q)
				2'd0:    ins = {v, 18'h0};
				2'd1:    ins = {6'h0, v, 12'h0};
				2'd2:    ins = {12'h0, v, 6'h0};
				default: ins = {18'h0, v};
			endcase
			gb_n  = gb_q | ins;
			pad_n = pad_i;
			if (cnt_q != 2'd3) begin
				if (in_last) begin
					cmd_c.nres = 3'd1;
					cmd_c.last = 1'b1;
					cmd_c.bad  = 1'b1;
					push_c     = 1'b1;
					gb_n       = '0;
					cnt_n      = '0;
					pad_n      = '0;
				end else begin
					cnt_n = cnt_q + 2'd1;
				end
			end else begin
				if (pad_i >= 3'd3) begin
					if (in_last) begin
						cmd_c.nres = 3'd1;
						cmd_c.last = 1'b1;
						cmd_c.bad  = 1'b1;
						push_c     = 1'b1;
					end
				end else begin
					cmd_c.bytes[0] = gb_n[23:16];
					cmd_c.bytes[1] = gb_n[15:8];
					cmd_c.bytes[2] = gb_n[7:0];
					cmd_c.nres     = 3'd3 - pad_i;
					cmd_c.last     = in_last;
					push_c         = 1'b1;
				end
				gb_n  = '0;
				cnt_n = '0;
				pad_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
			gb_q   <= '0;
			cnt_q  <= '0;
			pad_q  <= '0;
		end else if (cfg_we) begin
			mode_q <= mode_t'(cfg_mode);
			gb_q   <= '0;
			cnt_q  <= '0;
			pad_q  <= '0;
		end else if (in_fire) begin
			gb_q  <= gb_n;
			cnt_q <= cnt_n;
			pad_q <= pad_n;
		end
	end

	assign push = in_fire && push_c;
	assign cmd  = cmd_c;

endmodule
`default_nettype wire

[rtl/b64u_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module b64u_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire b64u_pkg::cmd_t  wr_cmd,
	input  wire logic            pop,
	output logic                 full,
	output logic                 not_empty,
	output b64u_pkg::cmd_t       rd_cmd
);
	import b64u_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign full      = (cnt_q == (PW + 1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_cmd    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/b64u_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module b64u_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire b64u_pkg::cmd_t  q_cmd,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_byte,
	output logic                 out_last,
	output logic                 out_bad
);
	import b64u_pkg::*;

	logic [1:0] k_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       bad_q;
	logic       load;
	logic       final_res;
	logic [2:0] last_idx;

	assign last_idx  = q_cmd.nres - 3'd1;
	assign final_res = ({1'b0, k_q} == last_idx);
	assign load      = q_valid && (!valid_q || out_ready);
	assign pop       = load && final_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= final_res ? 2'd0 : k_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= q_cmd.bytes[k_q];
			last_q <= q_cmd.last && final_res;
			bad_q  <= q_cmd.bad;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_bad   = bad_q;

endmodule
`default_nettype wire

[rtl/base64url_stream_codec.sv]
// a finished group is queued, then its results pass one at a time to the output register
// throughput: one item in per cycle while the queue has room; one result out per cycle
// while m_tready is high; encoding is paced by the single-result output register
// reset: arst_n clears mode to encode, the partial group, the queue and the output valid
`timescale 1ns / 1ps
`default_nettype none
`include "base64url_stream_codec_macros.svh"
module base64url_stream_codec (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // in_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic             m_tlast,
	output logic             m_tuser,   // bad_length
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);
	import b64u_pkg::*;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_valid;
	logic in_fire;
	cmd_t wr_cmd;
	cmd_t rd_cmd;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign in_fire   = s_tvalid && s_tready;

	b64u_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_mode (cfg_data),
		.in_fire  (in_fire),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.push     (q_push),
		.cmd      (wr_cmd)
	);

	b64u_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_cmd    (wr_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.rd_cmd    (rd_cmd)
	);

	b64u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (rd_cmd),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast),
		.out_bad   (m_tuser)
	);

	`B64U_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid)
	`B64U_ASSERT_NOW(a_push_space, q_push, !q_full)
	`B64U_ASSERT_NOW(a_error_is_last, m_tvalid && m_tuser, m_tlast && m_tdata == 8'h00)

endmodule
`default_nettype wire

[test/base64url_stream_codec_test.sv]
`timescale 1ns / 1ps
module base64url_stream_codec_test;
	import b64u_pkg::*;

	localparam logic [0:63][7:0] URL_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bad;
	} symbol_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;  // in_byte
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // out_byte
	logic       m_tlast;
	logic       m_tuser;          // bad_length
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;

	// mirror of the codec state
	mode_t       codec_mode = MODE_ENC;
	logic [23:0] grp_bits = '0;
	logic [1:0]  grp_count = '0;
	logic [2:0]  pad_count = '0;

	symbol_t symbols_due[$];
	int      error_count = 0;
	int      items_sent = 0;
	int      outputs_seen = 0;
	bit      quiet_links = 1'b0;
	int      hold_cycles = 0;

	base64url_stream_codec i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("base64url_stream_codec: mismatch");
		$finish;
	end

	function automatic void report_error(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		for (int i = 0; i < 64; i++) begin
			if (URL_ALPHABET[i] == c) begin
				return 6'(i);
			end
		end
		return 6'd0;
	endfunction

	function automatic void clear_group();
		grp_bits = '0;
		grp_count = '0;
		pad_count = '0;
	endfunction

	function automatic void push_symbol(input logic [7:0] d, input logic l, input logic b);
		symbol_t s;
		s.data = d;
		s.last = l;
		s.bad = b;
		symbols_due.push_back(s);
	endfunction

	// works out the outputs that one accepted item causes
	function automatic void codec_step(input logic [7:0] b, input logic last);
		int n;
		int nchars;
		int nbytes;
		if (codec_mode == MODE_ENC) begin
			if (grp_count > 2'd2) begin
				clear_group();
			end
			grp_bits = grp_bits | (24'(b) << (16 - 8 * int'(grp_count)));
			n = int'(grp_count) + 1;
			if (n < 3 && !last) begin
				grp_count = 2'(n);
			end else begin
				nchars = (n >= 3) ? 4 : n + 1;
				for (int j = 0; j < 4; j++) begin
					push_symbol((j < nchars) ? URL_ALPHABET[6'(grp_bits >> (18 - 6 * j))]
						: PAD_CHAR, (j == 3) ? last : 1'b0, 1'b0);
				end
				clear_group();
			end
		end else begin
			if (b == PAD_CHAR && pad_count < 3'd4) begin
				pad_count = pad_count + 3'd1;
			end
			grp_bits = grp_bits | (24'(sextet_of(b)) << (18 - 6 * int'(grp_count)));
			if (grp_count < 2'd3) begin
				if (last) begin
					clear_group();
					push_symbol(8'h00, 1'b1, 1'b1);
				end else begin
					grp_count = grp_count + 2'd1;
				end
			end else begin
				nbytes = (pad_count >= 3'd3) ? 0 : 3 - int'(pad_count);
				if (nbytes == 0) begin
					if (last) begin
						push_symbol(8'h00, 1'b1, 1'b1);
					end
				end else begin
					for (int j = 0; j < nbytes; j++) begin
						push_symbol(8'(grp_bits >> (16 - 8 * j)),
							(j + 1 == nbytes) ? last : 1'b0, 1'b0);
					end
				end
				clear_group();
			end
		end
	endfunction

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= quiet_links || ($urandom_range(0, 99) >= 7);
		end
	end

	always @(posedge clk) begin : check_outputs
		symbol_t want;
		if (arst_n && m_tvalid && m_tready) begin
			outputs_seen++;
			if (symbols_due.size() == 0) begin
				report_error($sformatf("output item %0d unexpected: data %h last %b bad %b",
					outputs_seen, m_tdata, m_tlast, m_tuser));
			end else begin
				want = symbols_due.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.last || m_tuser !== want.bad) begin
					report_error($sformatf(
						"output item %0d: want data %h last %b bad %b, got %h %b %b",
						outputs_seen, want.data, want.last, want.bad,
						m_tdata, m_tlast, m_tuser));
				end
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last);
		while (!quiet_links && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		codec_step(b, last);
		items_sent++;
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drain();
		while (symbols_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_mode(input mode_t m);
		wait_drain();
		// a group may still be in flight without any output
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		codec_mode = m;
		clear_group();
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 99) < 90) begin
			return URL_ALPHABET[$urandom_range(0, 63)];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_byte_message(input int len);
		for (int k = 0; k < len; k++) begin
			send_item(8'($urandom_range(0, 255)), k == len - 1);
		end
	endtask

	task automatic send_text_message();
		int groups;
		int len;
		int pads;
		int r;
		bit final_grp;
		groups = $urandom_range(1, 3);
		for (int g = 0; g < groups; g++) begin
			final_grp = (g == groups - 1);
			len = 4;
			pads = 0;
			r = $urandom_range(0, 99);
			if (final_grp) begin
				if (r < 55) pads = 0;
				else if (r < 75) pads = 1;
				else if (r < 87) pads = 2;
				else if (r < 93) pads = $urandom_range(3, 4);
				else len = $urandom_range(1, 3);
			end else if (r < 6) begin
				pads = 4;
			end else if (r < 10) begin
				pads = $urandom_range(1, 2);
			end
			for (int k = 0; k < len; k++) begin
				send_item((k >= 4 - pads) ? PAD_CHAR : pick_char(), final_grp && k == len - 1);
			end
		end
	endtask

	task automatic test_encode_directed();
		// full group of dashes, one byte with underscore, two bytes
		send_item(8'hFB, 1'b0);
		send_item(8'hEF, 1'b0);
		send_item(8'hBE, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'h80, 1'b1);
		stop_sending();
	endtask

	task automatic test_decode_directed();
		write_mode(MODE_DEC);
		// unknown characters and trailing pad
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h2A, 1'b0);
		send_item(PAD_CHAR, 1'b1);
		// empty middle group
		send_item(PAD_CHAR, 1'b0);
		send_item("A", 1'b0);
		send_item(PAD_CHAR, 1'b0);
		send_item(PAD_CHAR, 1'b0);
		// pad in the middle of a group
		send_item("Q", 1'b0);
		send_item(PAD_CHAR, 1'b0);
		send_item("B", 1'b0);
		send_item("_", 1'b0);
		// short final group
		send_item("Q", 1'b0);
		send_item("U", 1'b1);
		// empty final group
		send_item("A", 1'b0);
		send_item(PAD_CHAR, 1'b0);
		send_item(PAD_CHAR, 1'b0);
		send_item(PAD_CHAR, 1'b1);
		stop_sending();
	endtask

	task automatic test_random_traffic();
		int goal;
		for (int phase = 0; phase < 4; phase++) begin
			write_mode((phase % 2 == 0) ? MODE_DEC : MODE_ENC);
			quiet_links = (phase == 2);
			goal = items_sent + 22;
			while (items_sent < goal) begin
				if (codec_mode == MODE_ENC) begin
					send_byte_message($urandom_range(1, 12));
				end else begin
					send_text_message();
				end
				if (phase == 1 && items_sent >= goal - 20 && items_sent < goal - 12) begin
					stop_sending();
					wait_drain();
				end
			end
			stop_sending();
			quiet_links = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		write_mode(MODE_ENC);
		quiet_links = 1'b1;
		hold_cycles <= 150;
		send_byte_message(30);
		stop_sending();
		wait_drain();
		quiet_links = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_directed();
		test_decode_directed();
		test_random_traffic();
		test_backpressure();
		wait_drain();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("base64url_stream_codec: match");
		end else begin
			$display("base64url_stream_codec: mismatch");
		end
		$finish;
	end

endmodule
